@@ hdl/gas_pkg.sv @@
// gas_pkg: shared types and constants for the gate actuator sequencer.
// Used by gate_actuator_sequencer; depends on nothing.
package gas_pkg;

  // Time counter width default and widths of the travel and current registers
  localparam int unsigned TimeWidthDef = 16;
  localparam int unsigned TravelWidth  = 16;
  localparam int unsigned CurrentWidth = 10;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CFG_OPEN_TICKS    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_CLOSE_TICKS   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_CURRENT_LIMIT = 2'd2;

  localparam logic [TravelWidth-1:0]  OpenTicksRst    = 16'd100;
  localparam logic [TravelWidth-1:0]  CloseTicksRst   = 16'd100;
  localparam logic [CurrentWidth-1:0] CurrentLimitRst = 10'd100;

  // Stream payload widths
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 8;

  // Input tdata: [0] toggle_request, [1] stop_request, [11:2] load_current
  localparam int unsigned InToggleBit  = 0;
  localparam int unsigned InStopBit    = 1;
  localparam int unsigned InCurrentLsb = 2;

  // Item kind carried in tuser
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_MESSAGE = 1'b1;

  // Gate position codes
  typedef enum logic [1:0] {
    POS_HOME   = 2'd0,
    POS_CLOSED = 2'd1,
    POS_OPEN   = 2'd2
  } pos_e;

  // Result item, packed so that forward_drive lands in bit 0
  typedef struct packed {
    logic       pad;
    logic       stopped;
    logic       move_done;
    logic [1:0] position_state;
    logic       bridge_enable;
    logic       reverse_drive;
    logic       forward_drive;
  } result_t;

endpackage

@@ hdl/gate_actuator_sequencer.sv @@
// gate_actuator_sequencer: remote gate actuator sequencer, top level.
// Depends on gas_pkg for codes, widths and the result layout.
//
// Usage:
//   Slave stream s_axis_* carries items: tuser = 1 for a remote command
//   message (latches toggle and stop requests), tuser = 0 for a timer tick
//   (advances the sequencer, carries the load current). Every tick yields
//   one result on master stream m_axis_* with the drive outputs, position,
//   move-done and stop flags; a message yields nothing.
//   The cfg_* channel writes open_ticks (0), close_ticks (1) and
//   current_limit (2); it is always ready. Other indexes are ignored.
// Pipeline and throughput:
//   An accepted item is held in the input register and is processed as it
//   leaves it; a tick's result is then registered in the output register,
//   which drives m_axis_tvalid. One item per cycle is taken while no tick
//   is held back by a waiting result that the receiver has not taken.
// Reset:
//   Gate at home, no latched requests, counters cleared, travel times and
//   current limit back to 100, both registers empty.
// Stall:
//   When m_axis_tready is low and a result waits, ticks hold in the input
//   register; messages still drain, and s_axis_tready drops once full.
module gate_actuator_sequencer #(
  parameter int unsigned TIME_WIDTH = gas_pkg::TimeWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] toggle_request, [1] stop_request, [11:2] load_current, [15:12] zero
  input  logic [gas_pkg::InDataWidth-1:0]   s_axis_tdata,
  // [0] action
  input  logic                              s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] forward_drive, [1] reverse_drive, [2] bridge_enable,
  // [4:3] position_state, [5] move_done, [6] stopped, [7] zero
  output logic [gas_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gas_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [gas_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned CmpW = (TW + 1 > gas_pkg::TravelWidth) ? TW + 1
                                                                 : gas_pkg::TravelWidth;
  localparam logic [TW-1:0] TimeMax = {TW{1'b1}};

  // Configuration registers
  logic [gas_pkg::TravelWidth-1:0]  open_ticks_q, close_ticks_q;
  logic [gas_pkg::CurrentWidth-1:0] current_limit_q;

  // Input register
  logic                            in_valid_q;
  logic                            in_msg_q;
  logic [gas_pkg::InDataWidth-1:0] in_data_q;

  // Sequencer state
  gas_pkg::pos_e   pos_q, pos_d;
  logic            toggle_q, toggle_d;
  logic            stop_q, stop_d;
  logic [TW-1:0]   run_q, run_d;
  logic [TW-1:0]   bank_q, bank_d;

  // Output register
  logic             out_valid_q;
  gas_pkg::result_t out_q, res_d;

  logic advance;
  logic in_accept;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_ticks_q    <= gas_pkg::OpenTicksRst;
      close_ticks_q   <= gas_pkg::CloseTicksRst;
      current_limit_q <= gas_pkg::CurrentLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gas_pkg::CFG_OPEN_TICKS:    open_ticks_q    <= cfg_data_i;
        gas_pkg::CFG_CLOSE_TICKS:   close_ticks_q   <= cfg_data_i;
        gas_pkg::CFG_CURRENT_LIMIT: current_limit_q <= cfg_data_i[gas_pkg::CurrentWidth-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held item when it makes no result or the result slot frees
  assign advance       = in_valid_q && (in_msg_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Hold the accepted request in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_msg_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Sequencer next state and result
  logic [gas_pkg::CurrentWidth-1:0] cur;
  logic [TW:0]                      sum;
  logic [gas_pkg::TravelWidth-1:0]  travel;
  logic                             finish;
  logic [TW-1:0]                    run_inc;
  logic [TW-1:0]                    bank_add;
  logic                             fwd, rev, done;

  assign cur      = in_data_q[gas_pkg::InCurrentLsb +: gas_pkg::CurrentWidth];
  assign sum      = {1'b0, run_q} + {1'b0, bank_q};
  assign travel   = (pos_q == gas_pkg::POS_CLOSED) ? open_ticks_q : close_ticks_q;
  assign finish   = (CmpW'(sum) >= CmpW'(travel)) || (cur >= current_limit_q);
  assign run_inc  = (run_q == TimeMax) ? run_q : run_q + TW'(1);
  assign bank_add = sum[TW] ? TimeMax : sum[TW-1:0];

  always_comb begin
    pos_d    = pos_q;
    toggle_d = toggle_q;
    stop_d   = stop_q;
    run_d    = run_q;
    bank_d   = bank_q;
    fwd      = 1'b0;
    rev      = 1'b0;
    done     = 1'b0;

    if (in_msg_q == gas_pkg::ACT_MESSAGE) begin
      // Latch the remote requests
      toggle_d = in_data_q[gas_pkg::InToggleBit];
      stop_d   = in_data_q[gas_pkg::InStopBit];
    end else if (stop_q) begin
      // Bank the elapsed segment while stopped
      if (run_q != '0) begin
        bank_d = bank_add;
        run_d  = '0;
      end
    end else if (toggle_q || run_q != '0) begin
      case (pos_q)
        gas_pkg::POS_HOME: begin
          pos_d = gas_pkg::POS_CLOSED;
        end
        gas_pkg::POS_CLOSED, gas_pkg::POS_OPEN: begin
          if (finish) begin
            toggle_d = 1'b0;
            pos_d    = (pos_q == gas_pkg::POS_CLOSED) ? gas_pkg::POS_OPEN
                                                      : gas_pkg::POS_CLOSED;
            run_d    = '0;
            bank_d   = '0;
            done     = 1'b1;
          end else begin
            fwd   = (pos_q == gas_pkg::POS_CLOSED);
            rev   = (pos_q == gas_pkg::POS_OPEN);
            run_d = run_inc;
          end
        end
        default: begin
          // Invalid position code: drop the request, drive nothing
          toggle_d = 1'b0;
          run_d    = '0;
        end
      endcase
    end

    res_d.pad            = 1'b0;
    res_d.stopped        = stop_q;
    res_d.move_done      = done;
    res_d.position_state = pos_d;
    res_d.bridge_enable  = fwd | rev;
    res_d.reverse_drive  = rev;
    res_d.forward_drive  = fwd;
  end

  // Update sequencer state as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= gas_pkg::POS_HOME;
      toggle_q <= 1'b0;
      stop_q   <= 1'b0;
      run_q    <= '0;
      bank_q   <= '0;
    end else if (advance) begin
      pos_q    <= pos_d;
      toggle_q <= toggle_d;
      stop_q   <= stop_d;
      run_q    <= run_d;
      bank_q   <= bank_d;
    end
  end

  // Hold the tick result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_msg_q == gas_pkg::ACT_TICK) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_msg_q == gas_pkg::ACT_TICK) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ bench/tb_gate_actuator_sequencer.sv @@
// tb_gate_actuator_sequencer: self-checking bench for the gate actuator sequencer.
// Drives command messages and timer ticks and predicts every drive report.
// Depends on gas_pkg and gate_actuator_sequencer.
`timescale 1ns / 1ps

module tb_gate_actuator_sequencer;

  // One request on the input stream
  typedef struct packed {
    logic       action;
    logic       toggle;
    logic       stop;
    logic [9:0] current;
  } gate_req_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [gas_pkg::InDataWidth-1:0]     s_axis_tdata  = '0;
  logic                                s_axis_tuser  = gas_pkg::ACT_TICK;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [gas_pkg::OutDataWidth-1:0]    m_axis_tdata;
  logic                                cfg_valid_i   = 1'b0;
  logic                                cfg_ready_o;
  logic [gas_pkg::CfgIdxWidth-1:0]     cfg_index_i   = gas_pkg::CFG_OPEN_TICKS;
  logic [gas_pkg::CfgDataWidth-1:0]    cfg_data_i    = '0;

  gate_req_t         pending_requests[$];
  gas_pkg::result_t  expected_drive[$];
  gate_req_t         offered_req;
  idle_mode_e        idle_mode = IDLE_NONE;
  int unsigned       fail_count = 0;

  // Predicted configuration
  logic [15:0] open_travel  = gas_pkg::OpenTicksRst;
  logic [15:0] close_travel = gas_pkg::CloseTicksRst;
  logic [9:0]  amp_limit    = gas_pkg::CurrentLimitRst;

  // Predicted sequencer state
  logic [1:0]  gate_pos       = gas_pkg::POS_HOME;
  logic        toggle_latched = 1'b0;
  logic        stop_held      = 1'b0;
  logic [15:0] run_count      = '0;
  logic [15:0] banked_count   = '0;

  gate_actuator_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Advance the predicted sequencer by one accepted request
  task automatic track_request(input gate_req_t req);
    gas_pkg::result_t res;
    logic [16:0]      elapsed;
    logic [15:0]      travel;
    res = '0;
    if (req.action == gas_pkg::ACT_MESSAGE) begin
      toggle_latched = req.toggle;
      stop_held      = req.stop;
      return;
    end
    if (stop_held) begin
      // bank the time driven so far, saturating
      if (run_count != 16'd0) begin
        elapsed      = {1'b0, banked_count} + {1'b0, run_count};
        banked_count = elapsed[16] ? 16'hFFFF : elapsed[15:0];
        run_count    = '0;
      end
    end else if (toggle_latched || run_count != 16'd0) begin
      case (gate_pos)
        gas_pkg::POS_HOME: begin
          gate_pos = gas_pkg::POS_CLOSED;
        end
        gas_pkg::POS_CLOSED, gas_pkg::POS_OPEN: begin
          travel  = (gate_pos == gas_pkg::POS_CLOSED) ? open_travel : close_travel;
          elapsed = {1'b0, run_count} + {1'b0, banked_count};
          if (elapsed >= {1'b0, travel} || req.current >= amp_limit) begin
            toggle_latched = 1'b0;
            gate_pos       = (gate_pos == gas_pkg::POS_CLOSED) ? gas_pkg::POS_OPEN
                                                               : gas_pkg::POS_CLOSED;
            run_count      = '0;
            banked_count   = '0;
            res.move_done  = 1'b1;
          end else begin
            if (gate_pos == gas_pkg::POS_CLOSED) res.forward_drive = 1'b1;
            else res.reverse_drive = 1'b1;
            if (run_count != 16'hFFFF) run_count = run_count + 16'd1;
          end
        end
        default: begin
          toggle_latched = 1'b0;
          run_count      = '0;
        end
      endcase
    end
    res.bridge_enable  = res.forward_drive | res.reverse_drive;
    res.position_state = gate_pos;
    res.stopped        = stop_held;
    expected_drive.push_back(res);
  endtask

  function automatic bit sender_pause();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99, 0) < 62;
      IDLE_BOTH:   return $urandom_range(99, 0) < 7;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99, 0) < 62;
      IDLE_BOTH:     return $urandom_range(99, 0) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: hold a request until taken, then offer the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_request(offered_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && !sender_pause()) begin
          offered_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, offered_req.current, offered_req.stop,
                            offered_req.toggle};
          s_axis_tuser  <= offered_req.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each report against the oldest prediction
  always @(posedge clk_i) begin
    gas_pkg::result_t want;
    gas_pkg::result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_drive.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_drive.pop_front();
          if (got !== want) begin
            $display("%0t: report mismatch, expected %h, actual %h",
                     $time, want, got);
            fail_count++;
          end
        end
      end
      m_axis_tready <= !receiver_stall();
    end
  end

  task automatic write_cfg(input logic [gas_pkg::CfgIdxWidth-1:0] idx,
                           input logic [gas_pkg::CfgDataWidth-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      gas_pkg::CFG_OPEN_TICKS:    open_travel  = value;
      gas_pkg::CFG_CLOSE_TICKS:   close_travel = value;
      gas_pkg::CFG_CURRENT_LIMIT: amp_limit    = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_travel(input logic [15:0] open_t, input logic [15:0] close_t,
                            input logic [9:0] limit);
    write_cfg(gas_pkg::CFG_OPEN_TICKS, open_t);
    write_cfg(gas_pkg::CFG_CLOSE_TICKS, close_t);
    write_cfg(gas_pkg::CFG_CURRENT_LIMIT, {6'b0, limit});
  endtask

  // Message: the current bits are don't-care, so randomize them
  task automatic add_message(input logic toggle, input logic stop);
    gate_req_t req;
    req.action  = gas_pkg::ACT_MESSAGE;
    req.toggle  = toggle;
    req.stop    = stop;
    req.current = 10'($urandom_range(1023, 0));
    pending_requests.push_back(req);
  endtask

  // Tick: the request bits are don't-care, so randomize them
  task automatic add_tick(input logic [9:0] current);
    gate_req_t req;
    req.action  = gas_pkg::ACT_TICK;
    req.toggle  = 1'($urandom_range(1, 0));
    req.stop    = 1'($urandom_range(1, 0));
    req.current = current;
    pending_requests.push_back(req);
  endtask

  // Mostly below the limit; now and then at or above it
  function automatic logic [9:0] pick_current();
    if (amp_limit == 10'd0 || $urandom_range(9, 0) == 0)
      return 10'($urandom_range(1023, amp_limit));
    return 10'($urandom_range(amp_limit - 1, 0));
  endfunction

  // Toggle, then a random run of ticks, with an occasional stop and resume
  task automatic add_gate_session();
    int longest;
    int span;
    int halt_at;
    int i;
    longest = int'((open_travel > close_travel) ? open_travel : close_travel);
    if (longest > 20) longest = 20;
    span    = int'($urandom_range(longest + 2, 1));
    halt_at = ($urandom_range(3, 0) == 0) ? int'($urandom_range(span - 1, 0)) : -1;
    add_message(1'b1, 1'b0);
    for (i = 0; i < span; i++) begin
      if (i == halt_at) begin
        add_message(1'($urandom_range(1, 0)), 1'b1);
        repeat ($urandom_range(3, 1)) add_tick(pick_current());
        add_message(1'b1, 1'b0);
      end else if ($urandom_range(15, 0) == 0) begin
        // drop the toggle mid-move; the move must carry on
        add_message(1'b0, 1'b0);
      end
      add_tick(pick_current());
    end
  endtask

  task automatic fill_random(input int count);
    while (pending_requests.size() < count) begin
      if ($urandom_range(9, 0) < 7) add_gate_session();
      else if ($urandom_range(1, 0) == 1)
        add_message(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      else add_tick(10'($urandom_range(1023, 0)));
    end
  endtask

  // Wait until every request is taken and every report is back
  task automatic drain();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full open with stop and resume, overcurrent close, stop while closed and mid-move
    set_travel(16'd3, 16'd2, 10'd1023);
    add_tick(10'd0);
    add_message(1'b1, 1'b0);
    add_tick(10'd0);
    add_tick(10'd0);
    add_message(1'b0, 1'b0);
    add_tick(10'd5);
    add_message(1'b0, 1'b1);
    add_tick(10'd0);
    add_tick(10'd1023);
    add_message(1'b1, 1'b0);
    add_tick(10'd0);
    add_tick(10'd0);
    add_message(1'b1, 1'b0);
    add_tick(10'd1023);
    add_message(1'b1, 1'b1);
    add_tick(10'd0);
    add_message(1'b1, 1'b0);
    add_tick(10'd1022);
    add_message(1'b1, 1'b1);
    add_tick(10'd0);
    drain();

    // Shorten the travel to the banked time: resume completes at once
    write_cfg(gas_pkg::CFG_OPEN_TICKS, 16'd1);
    add_message(1'b1, 1'b0);
    add_tick(10'd0);
    add_tick(10'd0);
    drain();

    // Random phases, each with its own settings and one of four idling patterns
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_travel(16'd5, 16'd7, 10'd600);
        1: set_travel(16'd1, 16'hFFFF, 10'd1023);
        2: set_travel(16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)), 10'd0);
        3: set_travel(16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)),
                      10'($urandom_range(1023, 0)));
        4: set_travel(16'hFFFF, 16'd1, 10'($urandom_range(900, 200)));
        default: set_travel(16'($urandom_range(20, 2)), 16'($urandom_range(20, 2)),
                            10'($urandom_range(1023, 100)));
      endcase
      idle_mode = idle_mode_e'(p % 4);
      fill_random(170);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
